@@ hdl/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, constants and the quarter-wave sine table of the tone power
// correlator.
// ----------------------------------------------------------------------------
package tpc_pkg;

  // Arithmetic right shift applied to each sample-by-wave product
  localparam int unsigned CORR_SHIFT = 15;
  // Tones: centre, lower neighbour, upper neighbour
  localparam int unsigned NUM_TONES  = 3;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // Squaring sequence: two partial products for each of six accumulators
  localparam int unsigned SQ_STEPS = 2 * 2 * NUM_TONES;
  localparam int unsigned SQ_CNT_W = $clog2(SQ_STEPS);

  typedef logic [SQ_CNT_W-1:0] sq_sel_t;

  // Register indexes on the configuration port (byte address / 4)
  typedef enum logic [1:0] {
    REG_CENTER_STEP = 2'd0,
    REG_LOWER_STEP  = 2'd1,
    REG_UPPER_STEP  = 2'd2,
    REG_BAND_MODE   = 2'd3
  } reg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SQUARE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;     // take the input word, form the products
    logic    acc_en;   // add products into accumulators, advance phases
    logic    sq_en;    // issue one squaring partial product
    sq_sel_t sq_sel;   // accumulator select in [3:1], high-half flag in [0]
    logic    finish;   // load the power result, clear the run state
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;        // word held in the product stage ends the run
    logic out_full;    // result register still waits for the sink
  } ctrl_sts_t;

  // Quarter-wave sine, Q15
  localparam logic signed [15:0] SINE_TABLE [64] = '{
    16'sd0,     16'sd804,   16'sd1608,  16'sd2410,  16'sd3212,  16'sd4011,
    16'sd4808,  16'sd5602,  16'sd6393,  16'sd7179,  16'sd7962,  16'sd8739,
    16'sd9512,  16'sd10278, 16'sd11039, 16'sd11793, 16'sd12539, 16'sd13279,
    16'sd14010, 16'sd14732, 16'sd15446, 16'sd16151, 16'sd16846, 16'sd17530,
    16'sd18204, 16'sd18868, 16'sd19519, 16'sd20159, 16'sd20787, 16'sd21403,
    16'sd22005, 16'sd22594, 16'sd23170, 16'sd23731, 16'sd24279, 16'sd24811,
    16'sd25329, 16'sd25831, 16'sd26318, 16'sd26789, 16'sd27244, 16'sd27683,
    16'sd28105, 16'sd28510, 16'sd28898, 16'sd29269, 16'sd29622, 16'sd29957,
    16'sd30274, 16'sd30572, 16'sd30852, 16'sd31113, 16'sd31356, 16'sd31579,
    16'sd31783, 16'sd31968, 16'sd32133, 16'sd32279, 16'sd32405, 16'sd32512,
    16'sd32598, 16'sd32665, 16'sd32713, 16'sd32740
  };

  // Full-wave sine from a 32-bit phase: quadrant in [31:30], index in [29:24]
  function automatic logic signed [15:0] wave_at(input logic [31:0] ph);
    logic [5:0]         idx;
    logic signed [15:0] mag;
    idx = ph[29:24];
    // mirror the index on odd quadrants
    if (ph[30]) begin
      mag = SINE_TABLE[~idx];
    end else begin
      mag = SINE_TABLE[idx];
    end
    // negate on the second half turn
    if (ph[31]) begin
      return -mag;
    end
    return mag;
  endfunction

endpackage

@@ hdl/tone_power_correlator.sv @@
// ----------------------------------------------------------------------------
// tone_power_correlator
// Single-bin quadrature correlator for a centre tone and two neighbours,
// with an APB register bank for phase steps and band mode.
// ----------------------------------------------------------------------------
// Each word passes the product stage, then the accumulate stage; the next word
// is taken only after the accumulate stage. A word with tlast then adds 12
// partial products on the shared 32x32 multiplier, a drain state and a finish
// state that loads the result register, plus any wait while the previous power
// word is still held; m_tvalid rises as the finish state loads that register.
// Synchronous reset clears the configuration registers, phases, accumulators and the output valid.
module tone_power_correlator
  import tpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample (signed)
  input  logic        s_tlast,
  // Power stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [63:0] power
);

  logic [31:0] center_step;
  logic [31:0] lower_step;
  logic [31:0] upper_step;
  logic        band_mode;
  reg_idx_t    reg_idx;
  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_step <= '0;
      lower_step  <= '0;
      upper_step  <= '0;
      band_mode   <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_CENTER_STEP: center_step <= pwdata;
        REG_LOWER_STEP:  lower_step  <= pwdata;
        REG_UPPER_STEP:  upper_step  <= pwdata;
        REG_BAND_MODE:   band_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_CENTER_STEP: prdata = center_step;
      REG_LOWER_STEP:  prdata = lower_step;
      REG_UPPER_STEP:  prdata = upper_step;
      REG_BAND_MODE:   prdata = {31'd0, band_mode};
      default:         prdata = '0;
    endcase
  end

  tpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .sample      ($signed(s_tdata)),
    .last_sample (s_tlast),
    .center_step (center_step),
    .lower_step  (lower_step),
    .upper_step  (upper_step),
    .band_mode   (band_mode),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .power       (m_tdata)
  );

endmodule

@@ hdl/tpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpc_ctrl
// Sequencer of the correlator: input handshake, accumulate step, squaring
// sequence over the shared multiplier and hand-off of the result.
// ----------------------------------------------------------------------------
module tpc_ctrl
  import tpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t  state, state_next;
  sq_sel_t sq_cnt, sq_cnt_next;

  // State and squaring counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      sq_cnt <= '0;
    end else begin
      state  <= state_next;
      sq_cnt <= sq_cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    sq_cnt_next = sq_cnt;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.sq_sel  = sq_cnt;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        if (sts.last) begin
          sq_cnt_next = '0;
          state_next  = ST_SQUARE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SQUARE: begin
        cmd.sq_en = 1'b1;
        if (sq_cnt == sq_sel_t'(SQ_STEPS - 1)) begin
          state_next = ST_DRAIN;
        end else begin
          sq_cnt_next = sq_sel_t'(sq_cnt + 1'b1);
        end
      end
      ST_DRAIN: begin
        // last partial product is added in this cycle
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!sts.out_full) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/tpc_datapath.sv @@
// ----------------------------------------------------------------------------
// tpc_datapath
// Three correlator lanes (phase, I and Q accumulators), a shared 32x32
// multiplier for the squaring, power sums and the output register.
// ----------------------------------------------------------------------------
module tpc_datapath
  import tpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output ctrl_sts_t          sts,
  input  logic signed [15:0] sample,
  input  logic               last_sample,
  input  logic [31:0]        center_step,
  input  logic [31:0]        lower_step,
  input  logic [31:0]        upper_step,
  input  logic               band_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        power
);

  logic [31:0]        phase    [NUM_TONES];
  logic [63:0]        acc_i    [NUM_TONES];
  logic [63:0]        acc_q    [NUM_TONES];
  logic signed [31:0] prod_c   [NUM_TONES];
  logic signed [31:0] prod_s   [NUM_TONES];
  logic signed [31:0] prod_c_next [NUM_TONES];
  logic signed [31:0] prod_s_next [NUM_TONES];
  logic [31:0]        steps    [NUM_TONES];
  logic               last_hold;

  logic [63:0] sq_val;
  logic [31:0] sq_b;
  logic [63:0] mprod;
  logic        add_vld;
  logic        add_high;
  logic        add_side;
  logic [63:0] add_term;
  logic [63:0] center_sum;
  logic [63:0] side_sum;

  assign steps[0] = center_step;
  assign steps[1] = lower_step;
  assign steps[2] = upper_step;

  // Sample times cosine and sine for each lane
  always_comb begin
    for (int t = 0; t < NUM_TONES; t++) begin
      prod_c_next[t] = 32'(sample) * 32'(wave_at(phase[t] + QUARTER_TURN));
      prod_s_next[t] = 32'(sample) * 32'(wave_at(phase[t]));
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int t = 0; t < NUM_TONES; t++) begin
        prod_c[t] <= prod_c_next[t];
        prod_s[t] <= prod_s_next[t];
      end
      last_hold <= last_sample;
    end
  end

  // Accumulate, advance phases, clear at end of run
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int t = 0; t < NUM_TONES; t++) begin
        phase[t] <= '0;
        acc_i[t] <= '0;
        acc_q[t] <= '0;
      end
    end else if (cmd.acc_en) begin
      for (int t = 0; t < NUM_TONES; t++) begin
        phase[t] <= phase[t] + steps[t];
        acc_i[t] <= acc_i[t] + 64'(prod_c[t] >>> CORR_SHIFT);
        acc_q[t] <= acc_q[t] - 64'(prod_s[t] >>> CORR_SHIFT);
      end
    end
  end

  // Select squaring operand: I0, Q0, I1, Q1, I2, Q2
  always_comb begin
    case (cmd.sq_sel[SQ_CNT_W-1:1])
      3'd0:    sq_val = acc_i[0];
      3'd1:    sq_val = acc_q[0];
      3'd2:    sq_val = acc_i[1];
      3'd3:    sq_val = acc_q[1];
      3'd4:    sq_val = acc_i[2];
      3'd5:    sq_val = acc_q[2];
      default: sq_val = '0;
    endcase
    sq_b = cmd.sq_sel[0] ? sq_val[63:32] : sq_val[31:0];
  end

  // Partial product: lo*lo, or lo*hi for the cross term (mod 2^64)
  always_ff @(posedge clk) begin
    mprod    <= 64'(sq_val[31:0]) * 64'(sq_b);
    add_high <= cmd.sq_sel[0];
    add_side <= (cmd.sq_sel[SQ_CNT_W-1:1] != 3'd0) && (cmd.sq_sel[SQ_CNT_W-1:1] != 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      add_vld <= 1'b0;
    end else begin
      add_vld <= cmd.sq_en;
    end
  end

  // Cross term counts twice and lands 32 bits up
  assign add_term = add_high ? {mprod[30:0], 33'd0} : mprod;

  // Power sums for the centre tone and the two neighbours
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      center_sum <= '0;
      side_sum   <= '0;
    end else if (add_vld) begin
      if (add_side) begin
        side_sum <= side_sum + add_term;
      end else begin
        center_sum <= center_sum + add_term;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      power <= band_mode ? center_sum + (side_sum >> 1) : center_sum;
    end
  end

  assign sts.last     = last_hold;
  assign sts.out_full = out_valid;

endmodule
